[hw/rtl/ple_pkg.sv]
`default_nettype none

package ple_pkg;

  localparam int unsigned CMD_BITS = 3;
  localparam int unsigned POS_BITS = 5;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned LEN_BITS = 5;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_APPEND      = 3'd0,
    CMD_POP_HEAD    = 3'd1,
    CMD_INSERT_AT   = 3'd2,
    CMD_REMOVE_AT   = 3'd3,
    CMD_REMOVE_TAIL = 3'd4,
    CMD_READ_AT     = 3'd5,
    CMD_READ_HEAD   = 3'd6,
    CMD_READ_TAIL   = 3'd7
  } cmd_e;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic up;     // open a gap at the target and write the new entry there
    logic down;   // close the gap at the target
    logic clear;  // restart the read bus
  } cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/ple_req_if.sv]
`default_nettype none

interface ple_req_if;
  logic                                  valid;
  logic                                  ready;
  ple_pkg::cmd_e                         command;
  logic [ple_pkg::POS_BITS-1:0]          position;
  logic [ple_pkg::DATA_BITS-1:0]         data;

  modport source (output valid, command, position, data, input ready);
  modport sink (input valid, command, position, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/ple_rsp_if.sv]
`default_nettype none

interface ple_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  ok;
  logic [ple_pkg::DATA_BITS-1:0]         read_value;
  logic [ple_pkg::LEN_BITS-1:0]          length;

  modport source (output valid, ok, read_value, length, input ready);
  modport sink (input valid, ok, read_value, length, output ready);
endinterface

`default_nettype wire

[hw/rtl/ple_cell.sv]
`default_nettype none

module ple_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW = 5,
  parameter int unsigned EB = 32
) (
  input  wire logic               clk,
  input  wire ple_pkg::cell_ctl_t ctl,
  input  wire logic [CW-1:0]      tgt,
  input  wire logic [CW-1:0]      sel,
  input  wire logic [EB-1:0]      wdata,
  input  wire logic [EB-1:0]      left,
  input  wire logic [EB-1:0]      right,
  input  wire logic [EB-1:0]      bus_in,
  output logic [EB-1:0]           entry,
  output logic [EB-1:0]           bus_out
);
  import ple_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  always_ff @(posedge clk) begin
    if (ctl.up) begin
      if (MY_IDX > tgt) begin
        entry <= left;
      end else if (MY_IDX == tgt) begin
        entry <= wdata;
      end
    end else if (ctl.down && (MY_IDX >= tgt)) begin
      entry <= right;
    end
  end

  // Read bus: OR the selected entry in and pass it on toward the tail.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      bus_out <= '0;
    end else begin
      bus_out <= bus_in | ((MY_IDX == sel) ? entry : '0);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/positional_list_engine_unit.sv]
// Bounded ordered list of DEPTH entries, ENTRY_BITS wide, head at index 0.
// req channel (valid/ready): command, position, data. One item per command.
// rsp channel (valid/ready): ok, read_value, length. Exactly one item per
// command, in command order. Rejected commands (full, empty, position out
// of range) return ok=0, read_value=0 and leave the list unchanged.
// Entries sit in a row of cells; insert and remove shift every cell above
// the target by one place, all at once. Reads travel along a read bus that
// moves one cell per cycle from head toward tail.
// After a command is taken, the read bus walks every cell (ST_SCAN); then
// the change is applied and the result registered (ST_APPLY).
// The next command is taken only after the previous one is applied.
// A new command is taken while the previous result still waits on rsp;
// when rsp stalls, the update and its result hold until the slot frees.
// Reset (rst, synchronous, active high) empties the list and drops any
// pending result. Entry contents are not cleared; only entries below the
// length are ever read.
`default_nettype none

module positional_list_engine_unit #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ENTRY_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ple_req_if.sink    req,
  ple_rsp_if.source  rsp
);
  import ple_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned W = (CW > POS_BITS) ? CW : POS_BITS;
  localparam logic [W-1:0] DEPTH_W = W'(DEPTH);
  localparam logic [IW-1:0] SCAN_LAST = IW'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  state_t                st;
  logic [IW-1:0]         scan_cnt;
  logic [CW-1:0]         count;
  logic                  ok_q;
  logic                  ins_q;
  logic                  shift_q;
  logic                  dec_q;
  logic                  rd_q;
  logic [CW-1:0]         tgt_q;
  logic [CW-1:0]         sel_q;
  logic [ENTRY_BITS-1:0] wdata_q;

  logic                  out_valid;
  logic                  out_ok;
  logic [DATA_BITS-1:0]  out_value;
  logic [LEN_BITS-1:0]   out_len;

  // Decode of the incoming item against the current length.
  logic                  ok_d;
  logic                  ins_d;
  logic                  shift_d;
  logic                  dec_d;
  logic                  rd_d;
  logic [CW-1:0]         tgt_d;
  logic [CW-1:0]         sel_d;
  logic [W-1:0]          pos_w;
  logic [W-1:0]          cnt_w;
  logic                  not_full;
  logic                  not_empty;

  logic                  accept;
  logic                  slot_free;
  logic                  apply;
  logic [CW-1:0]         count_next;
  cell_ctl_t             ctl;

  logic [ENTRY_BITS-1:0] entry [DEPTH];
  logic [ENTRY_BITS-1:0] bus   [DEPTH];
  logic [ENTRY_BITS-1:0] left_w  [DEPTH];
  logic [ENTRY_BITS-1:0] right_w [DEPTH];
  logic [ENTRY_BITS-1:0] busin_w [DEPTH];

  assign pos_w = W'(req.position);
  assign cnt_w = W'(count);
  assign not_full = cnt_w < DEPTH_W;
  assign not_empty = count != '0;

  always_comb begin
    ok_d = 1'b0;
    ins_d = 1'b0;
    shift_d = 1'b0;
    dec_d = 1'b0;
    rd_d = 1'b0;
    tgt_d = '0;
    sel_d = '0;
    unique case (req.command)
      CMD_APPEND: begin
        ok_d = not_full;
        ins_d = 1'b1;
        tgt_d = count;
      end
      CMD_POP_HEAD: begin
        ok_d = not_empty;
        shift_d = 1'b1;
        dec_d = 1'b1;
        rd_d = 1'b1;
      end
      CMD_INSERT_AT: begin
        ok_d = not_full && (pos_w <= cnt_w);
        ins_d = 1'b1;
        tgt_d = CW'(pos_w);
      end
      CMD_REMOVE_AT: begin
        ok_d = pos_w < cnt_w;
        shift_d = 1'b1;
        dec_d = 1'b1;
        rd_d = 1'b1;
        tgt_d = CW'(pos_w);
        sel_d = CW'(pos_w);
      end
      CMD_REMOVE_TAIL: begin
        ok_d = not_empty;
        dec_d = 1'b1;
        rd_d = 1'b1;
        sel_d = count - 1'b1;
      end
      CMD_READ_AT: begin
        ok_d = pos_w < cnt_w;
        rd_d = 1'b1;
        sel_d = CW'(pos_w);
      end
      CMD_READ_HEAD: begin
        ok_d = not_empty;
        rd_d = 1'b1;
      end
      CMD_READ_TAIL: begin
        ok_d = not_empty;
        rd_d = 1'b1;
        sel_d = count - 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  assign req.ready = (st == ST_IDLE);
  assign accept = req.valid && req.ready;
  assign slot_free = !out_valid || rsp.ready;
  assign apply = (st == ST_APPLY) && slot_free;

  always_comb begin
    count_next = count;
    if (ok_q && ins_q) begin
      count_next = count + 1'b1;
    end else if (ok_q && dec_q) begin
      count_next = count - 1'b1;
    end
  end

  assign ctl.up = apply && ok_q && ins_q;
  assign ctl.down = apply && ok_q && shift_q;
  assign ctl.clear = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      scan_cnt <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (apply) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (accept) begin
            st <= ST_SCAN;
            scan_cnt <= SCAN_LAST;
          end
        end
        ST_SCAN: begin
          if (scan_cnt == '0) begin
            st <= ST_APPLY;
          end else begin
            scan_cnt <= scan_cnt - 1'b1;
          end
        end
        ST_APPLY: begin
          if (slot_free) begin
            st <= ST_IDLE;
            count <= count_next;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // Item fields and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      ok_q <= ok_d;
      ins_q <= ins_d;
      shift_q <= shift_d;
      dec_q <= dec_d;
      rd_q <= rd_d;
      tgt_q <= tgt_d;
      sel_q <= sel_d;
      wdata_q <= ENTRY_BITS'(req.data);
    end
    if (apply) begin
      out_ok <= ok_q;
      out_value <= (ok_q && rd_q) ? DATA_BITS'(bus[DEPTH-1]) : '0;
      out_len <= LEN_BITS'(count_next);
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.ok = out_ok;
  assign rsp.read_value = out_value;
  assign rsp.length = out_len;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_w[i] = wdata_q;
      assign busin_w[i] = '0;
    end else begin : g_body
      assign left_w[i] = entry[i-1];
      assign busin_w[i] = bus[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_w[i] = entry[i];
    end else begin : g_inner
      assign right_w[i] = entry[i+1];
    end

    ple_cell #(
      .IDX (i),
      .CW  (CW),
      .EB  (ENTRY_BITS)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .tgt     (tgt_q),
      .sel     (sel_q),
      .wdata   (wdata_q),
      .left    (left_w[i]),
      .right   (right_w[i]),
      .bus_in  (busin_w[i]),
      .entry   (entry[i]),
      .bus_out (bus[i])
    );
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    W'(count) <= DEPTH_W)
    else $error("list length beyond depth");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (rst)
    apply && !ok_q |=> count == $past(count))
    else $error("rejected command changed the length");

  a_reject_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ok |-> out_value == '0)
    else $error("rejected command returned a value");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> st == ST_SCAN && ctl.up == 1'b0 && ctl.down == 1'b0)
    else $error("list changed during read bus walk");
`endif

endmodule

`default_nettype wire

[tb/positional_list_engine_unit_test.sv]
`default_nettype none

module positional_list_engine_unit_test;
  import ple_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int RANDOM_ITEMS = 930;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = LIST_DEPTH + 10;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic                 ok;
    logic [DATA_BITS-1:0] read_value;
    logic [LEN_BITS-1:0]  length;
  } outcome_t;

  typedef struct packed {
    cmd_e                 cmd;
    logic [POS_BITS-1:0]  pos;
    logic [DATA_BITS-1:0] data;
    logic                 typed;
    logic                 ok;
    logic [DATA_BITS-1:0] read_value;
    logic [LEN_BITS-1:0]  length;
  } plan_row_t;

  logic clk;
  logic rst;

  ple_req_if req_ch ();
  ple_rsp_if rsp_ch ();

  positional_list_engine_unit #(
    .DEPTH(LIST_DEPTH),
    .ENTRY_BITS(DATA_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the list, head at index 0.
  logic [DATA_BITS-1:0] stored [LIST_DEPTH];
  int                   list_len;

  outcome_t outcome_q [$];
  logic     cur_typed;
  outcome_t cur_outcome;
  logic     calm;

  int mismatches;
  int results_seen;
  int accepted;
  int rejected;
  int full_hits;
  int idle_cycles;
  int cmd_hits [8];

  // Row order matters: each typed row follows from the list built by the rows above it.
  plan_row_t plan [20] = '{
    '{CMD_READ_HEAD,   5'd0,  32'h0,        1'b1, 1'b0, 32'h0,        5'd0},
    '{CMD_POP_HEAD,    5'd0,  32'h0,        1'b1, 1'b0, 32'h0,        5'd0},
    '{CMD_READ_TAIL,   5'd0,  32'h0,        1'b1, 1'b0, 32'h0,        5'd0},
    '{CMD_REMOVE_TAIL, 5'd0,  32'h0,        1'b1, 1'b0, 32'h0,        5'd0},
    '{CMD_REMOVE_AT,   5'd0,  32'h0,        1'b1, 1'b0, 32'h0,        5'd0},
    '{CMD_READ_AT,     5'd0,  32'h0,        1'b1, 1'b0, 32'h0,        5'd0},
    '{CMD_INSERT_AT,   5'd1,  32'h1234_5678, 1'b1, 1'b0, 32'h0,       5'd0},
    '{CMD_INSERT_AT,   5'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0,       5'd1},
    '{CMD_APPEND,      5'd31, 32'h0,        1'b1, 1'b1, 32'h0,        5'd2},
    '{CMD_READ_HEAD,   5'd31, 32'h0,        1'b1, 1'b1, 32'hFFFF_FFFF, 5'd2},
    '{CMD_READ_TAIL,   5'd0,  32'h0,        1'b1, 1'b1, 32'h0,        5'd2},
    '{CMD_INSERT_AT,   5'd2,  32'hA5A5_A5A5, 1'b1, 1'b1, 32'h0,       5'd3},
    '{CMD_READ_AT,     5'd3,  32'h0,        1'b1, 1'b0, 32'h0,        5'd3},
    '{CMD_READ_AT,     5'd31, 32'h0,        1'b1, 1'b0, 32'h0,        5'd3},
    '{CMD_INSERT_AT,   5'd1,  32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0,       5'd0},
    '{CMD_READ_AT,     5'd2,  32'h0,        1'b0, 1'b0, 32'h0,        5'd0},
    '{CMD_REMOVE_AT,   5'd1,  32'h0,        1'b1, 1'b1, 32'h5A5A_5A5A, 5'd3},
    '{CMD_REMOVE_TAIL, 5'd0,  32'h0,        1'b1, 1'b1, 32'hA5A5_A5A5, 5'd2},
    '{CMD_POP_HEAD,    5'd0,  32'h0,        1'b1, 1'b1, 32'hFFFF_FFFF, 5'd1},
    '{CMD_REMOVE_AT,   5'd4,  32'h0,        1'b1, 1'b0, 32'h0,        5'd1}
  };

  function automatic outcome_t apply_command(cmd_e cmd, logic [POS_BITS-1:0] pos,
                                             logic [DATA_BITS-1:0] value);
    outcome_t res;
    int       n;
    res = '0;
    case (cmd)
      CMD_APPEND: begin
        if (list_len < LIST_DEPTH) begin
          stored[list_len] = value;
          list_len++;
          res.ok = 1'b1;
        end
      end
      CMD_POP_HEAD: begin
        if (list_len > 0) begin
          res.read_value = stored[0];
          for (n = 0; n + 1 < list_len; n++) stored[n] = stored[n + 1];
          list_len--;
          res.ok = 1'b1;
        end
      end
      CMD_INSERT_AT: begin
        if (list_len < LIST_DEPTH && int'(pos) <= list_len) begin
          for (n = list_len; n > int'(pos); n--) stored[n] = stored[n - 1];
          stored[pos] = value;
          list_len++;
          res.ok = 1'b1;
        end
      end
      CMD_REMOVE_AT: begin
        if (int'(pos) < list_len) begin
          res.read_value = stored[pos];
          for (n = int'(pos); n + 1 < list_len; n++) stored[n] = stored[n + 1];
          list_len--;
          res.ok = 1'b1;
        end
      end
      CMD_REMOVE_TAIL: begin
        if (list_len > 0) begin
          res.read_value = stored[list_len - 1];
          list_len--;
          res.ok = 1'b1;
        end
      end
      CMD_READ_AT: begin
        if (int'(pos) < list_len) begin
          res.read_value = stored[pos];
          res.ok = 1'b1;
        end
      end
      CMD_READ_HEAD: begin
        if (list_len > 0) begin
          res.read_value = stored[0];
          res.ok = 1'b1;
        end
      end
      default: begin
        if (list_len > 0) begin
          res.read_value = stored[list_len - 1];
          res.ok = 1'b1;
        end
      end
    endcase
    res.length = list_len[LEN_BITS-1:0];
    return res;
  endfunction

  task automatic note_mismatch(string what, logic [DATA_BITS-1:0] want,
                               logic [DATA_BITS-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("result %0d: %s expected %h got %h", results_seen, what, want, got);
  endtask

  // Drive one command at a falling edge and hold it until the block takes it.
  task automatic offer_command(cmd_e cmd, logic [POS_BITS-1:0] pos,
                               logic [DATA_BITS-1:0] value, logic typed, outcome_t want);
    if (!calm && $urandom_range(99) < 20) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.command  <= cmd;
    req_ch.position <= pos;
    req_ch.data     <= value;
    cur_typed       <= typed;
    cur_outcome     <= want;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Command side: predict at the edge that takes the item.
  always @(posedge clk) begin : take_command
    outcome_t predicted;
    if (!rst && req_ch.valid && req_ch.ready) begin
      predicted = apply_command(req_ch.command, req_ch.position, req_ch.data);
      outcome_q.push_back(cur_typed ? cur_outcome : predicted);
      cmd_hits[req_ch.command]++;
      accepted++;
      if (!predicted.ok) rejected++;
      if (predicted.ok && list_len == LIST_DEPTH &&
          (req_ch.command == CMD_APPEND || req_ch.command == CMD_INSERT_AT))
        full_hits++;
    end
  end

  always @(posedge clk) begin : check_result
    outcome_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (outcome_q.size() == 0) begin
        note_mismatch("unexpected result, read_value", '0, rsp_ch.read_value);
      end else begin
        want = outcome_q.pop_front();
        if (rsp_ch.ok !== want.ok)
          note_mismatch("ok", DATA_BITS'(want.ok), DATA_BITS'(rsp_ch.ok));
        if (rsp_ch.read_value !== want.read_value)
          note_mismatch("read_value", want.read_value, rsp_ch.read_value);
        if (rsp_ch.length !== want.length)
          note_mismatch("length", DATA_BITS'(want.length), DATA_BITS'(rsp_ch.length));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("no item moved for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, outcome_q.size());
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, a calm stretch, and one long hold-off.
  initial begin : result_side
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (!held && results_seen >= 500) begin
        held = 1'b1;
        hold_left = HOLD_OFF_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin : stimulus
    cmd_e                 cmd;
    logic [POS_BITS-1:0]  pos;
    logic                 growing;
    int                   roll;
    rst             <= 1'b1;
    calm            <= 1'b0;
    cur_typed       <= 1'b0;
    cur_outcome     <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.command  <= CMD_APPEND;
    req_ch.position <= '0;
    req_ch.data     <= '0;
    list_len = 0;
    growing = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      offer_command(plan[i].cmd, plan[i].pos, plan[i].data, plan[i].typed,
                    '{plan[i].ok, plan[i].read_value, plan[i].length});

    // Runs that fill the list to full and drain it to empty, with noise mixed in.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 300) calm <= 1'b1;
      if (k == 450) calm <= 1'b0;
      if (list_len == LIST_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
      if (list_len == 0 && $urandom_range(3) == 0) growing = 1'b1;
      roll = $urandom_range(99);
      if (roll < 10) begin
        cmd = cmd_e'($urandom_range(7));
      end else begin
        roll = $urandom_range(99);
        if (roll < 55)
          cmd = growing ? cmd_e'($urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT_AT)
                        : cmd_e'($urandom_range(2) == 0 ? CMD_POP_HEAD :
                                 $urandom_range(1) ? CMD_REMOVE_AT : CMD_REMOVE_TAIL);
        else if (roll < 75)
          cmd = cmd_e'($urandom_range(5, 7));
        else
          cmd = growing ? cmd_e'($urandom_range(2) == 0 ? CMD_POP_HEAD :
                                 $urandom_range(1) ? CMD_REMOVE_AT : CMD_REMOVE_TAIL)
                        : cmd_e'($urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT_AT);
      end
      if ($urandom_range(99) < 15)
        pos = POS_BITS'($urandom_range(31));
      else if (cmd == CMD_INSERT_AT)
        pos = POS_BITS'($urandom_range(list_len));
      else
        pos = POS_BITS'(list_len > 0 ? $urandom_range(list_len - 1) : 0);
      offer_command(cmd, pos, DATA_BITS'($urandom), 1'b0, '0);
    end
    req_ch.valid <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d commands taken, %0d rejected, list filled %0d times", accepted, rejected,
             full_hits);
    $display("per command: %0d %0d %0d %0d %0d %0d %0d %0d; %0d field mismatches",
             cmd_hits[0], cmd_hits[1], cmd_hits[2], cmd_hits[3], cmd_hits[4],
             cmd_hits[5], cmd_hits[6], cmd_hits[7], mismatches);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
